// File: sv/ssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg: shared widths for the segment distance pipeline
// Field widths, wide-arithmetic width and parameter quantization constants.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int CoordW   = 32;            // Q16.16 input coordinate
  localparam int DiffW    = CoordW + 1;    // coordinate difference
  localparam int DotW     = 2 * DiffW + 1; // dot product of two differences
  localparam int WideW    = 136;           // determinant and numerators
  localparam int FracW    = 32;            // fraction bits of a quantized parameter
  localparam int QW       = FracW + 1;     // quantized parameter, Q1.32
  localparam int DivSteps = FracW;         // one quotient bit per divider stage
  localparam int DistW    = 34;            // Q18.16 distance

endpackage

// File: sv/ssd_qdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_qdiv: pipelined fractional divider
// Returns floor(num * 2^32 / den) for 0 <= num <= den, one quotient bit a stage.
// ----------------------------------------------------------------------------
module ssd_qdiv (
  input  logic                              clk_i,
  input  logic                              adv_i,
  input  logic signed [ssd_pkg::WideW-1:0]  num_i,
  input  logic signed [ssd_pkg::WideW-1:0]  den_i,
  output logic        [ssd_pkg::QW-1:0]     q_o
);
  import ssd_pkg::*;

  logic [WideW-1:0] rem_q [DivSteps+1];
  logic [WideW-1:0] den_q [DivSteps+1];
  logic [FracW-1:0] quo_q [DivSteps+1];
  logic [DivSteps:0] zero_q;
  logic [DivSteps:0] one_q;

  logic [WideW-1:0] shl   [DivSteps+1];
  logic [DivSteps:0] ge;

  // Restoring step: double the remainder, subtract the divisor when it fits.
  always_comb begin
    shl[0] = '0;
    ge[0]  = 1'b0;
    for (int j = 1; j <= DivSteps; j++) begin
      shl[j] = {rem_q[j-1][WideW-2:0], 1'b0};
      ge[j]  = (shl[j] >= den_q[j-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q[0]  <= num_i;
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      zero_q[0] <= (num_i <= 0) || (den_i <= 0);
      one_q[0]  <= (num_i >= den_i);
      for (int j = 1; j <= DivSteps; j++) begin
        rem_q[j]  <= ge[j] ? (shl[j] - den_q[j-1]) : shl[j];
        den_q[j]  <= den_q[j-1];
        quo_q[j]  <= {quo_q[j-1][FracW-2:0], ge[j]};
        zero_q[j] <= zero_q[j-1];
        one_q[j]  <= one_q[j-1];
      end
    end
  end

  // Empty or non-positive ratio gives zero, a full ratio gives exactly one.
  always_comb begin
    if (zero_q[DivSteps]) begin
      q_o = '0;
    end else if (one_q[DivSteps]) begin
      q_o = {1'b1, {FracW{1'b0}}};
    end else begin
      q_o = {1'b0, quo_q[DivSteps]};
    end
  end

endmodule

// File: sv/segment_segment_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_segment_distance: shortest distance between two 3D segments
// Fully pipelined exact evaluation: Gram terms, clamped closest parameters,
// gap vector and integer square root.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one request, the twelve
//   Q16.16 end point coordinates of the two segments. A request is taken at
//   a rising edge with in_valid_i high and in_stall_o low.
//   Output channel: out_valid_o / out_stall_i carry distance_o, unsigned
//   Q18.16, one result for every request, in request order.
//   Depth: 80 register stages. The depth is set by the fractional
//   dividers (stages 9 to 41, one quotient bit a stage) and the square root
//   (stages 47 to 80, one root bit a stage); every other step takes one to
//   three stages.
//   Throughput: one request every cycle while out_stall_i does not hold
//   the pipeline.
//   Stall: while a result sits at the output and out_stall_i is high, the
//   whole pipeline holds and in_stall_o rises in the same cycle; nothing is
//   dropped or repeated. A pipeline with empty output slot never stalls.
//   Reset: rst_ni clears all stage valid bits; the data path needs no reset.
// ----------------------------------------------------------------------------
module segment_segment_distance (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [ssd_pkg::CoordW-1:0]  first_start_x_i,
  input  logic signed [ssd_pkg::CoordW-1:0]  first_start_y_i,
  input  logic signed [ssd_pkg::CoordW-1:0]  first_start_z_i,
  input  logic signed [ssd_pkg::CoordW-1:0]  first_end_x_i,
  input  logic signed [ssd_pkg::CoordW-1:0]  first_end_y_i,
  input  logic signed [ssd_pkg::CoordW-1:0]  first_end_z_i,
  input  logic signed [ssd_pkg::CoordW-1:0]  second_start_x_i,
  input  logic signed [ssd_pkg::CoordW-1:0]  second_start_y_i,
  input  logic signed [ssd_pkg::CoordW-1:0]  second_start_z_i,
  input  logic signed [ssd_pkg::CoordW-1:0]  second_end_x_i,
  input  logic signed [ssd_pkg::CoordW-1:0]  second_end_y_i,
  input  logic signed [ssd_pkg::CoordW-1:0]  second_end_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic        [ssd_pkg::DistW-1:0]   distance_o
);
  import ssd_pkg::*;

  // Stage map: 1 differences, 2 products, 3 dot sums, 4-5 wide products,
  // 6 determinant and numerators, 7-8 clamping, 9-41 dividers,
  // 42-43 gap vector, 44-46 squared norm, 47-80 square root.
  localparam int StgClamp = 8;
  localparam int StgQ     = StgClamp + DivSteps + 1;
  localparam int StgPg    = StgQ + 1;
  localparam int StgSq    = StgPg + 4;
  localparam int Lat      = StgSq + DistW;
  localparam int MHalf    = DiffW + 1;       // low half of a dot product
  localparam int GW       = DotW + 1;        // gap vector component, Q.48
  localparam int GHalf    = GW / 2;
  localparam int RadW     = 2 * DistW;       // square root radicand
  localparam int RemW     = DistW + 3;       // square root remainder

  typedef struct packed {
    logic signed [2*(DotW-MHalf)-1:0]   hh;
    logic signed [DotW:0]               hl;
    logic signed [DotW:0]               lh;
    logic        [2*MHalf-1:0]          ll;
  } part_t;

  typedef struct packed {
    logic signed [2*(GW-GHalf)-1:0]     hh;
    logic signed [GW:0]                 hl;
    logic        [2*GHalf-1:0]          ll;
  } sqp_t;

  // Split a wide signed product into four narrow partial products.
  function automatic part_t split_mul(input logic signed [DotW-1:0] a,
                                      input logic signed [DotW-1:0] b);
    logic signed [DotW-MHalf-1:0] ah;
    logic signed [DotW-MHalf-1:0] bh;
    logic signed [MHalf:0]        al;
    logic signed [MHalf:0]        bl;
    part_t r;
    ah   = a[DotW-1:MHalf];
    bh   = b[DotW-1:MHalf];
    al   = {1'b0, a[MHalf-1:0]};
    bl   = {1'b0, b[MHalf-1:0]};
    r.hh = ah * bh;
    r.hl = ah * bl;
    r.lh = al * bh;
    r.ll = a[MHalf-1:0] * b[MHalf-1:0];
    return r;
  endfunction

  function automatic logic signed [WideW-1:0] join_mul(input part_t p);
    return (WideW'($signed(p.hh)) <<< (2 * MHalf))
         + (WideW'($signed(p.hl)) <<< MHalf)
         + (WideW'($signed(p.lh)) <<< MHalf)
         + WideW'(p.ll);
  endfunction

  function automatic sqp_t split_sq(input logic signed [GW-1:0] g);
    logic signed [GW-GHalf-1:0] gh;
    logic signed [GHalf:0]      gl;
    sqp_t r;
    gh   = g[GW-1:GHalf];
    gl   = {1'b0, g[GHalf-1:0]};
    r.hh = gh * gh;
    r.hl = gh * gl;
    r.ll = g[GHalf-1:0] * g[GHalf-1:0];
    return r;
  endfunction

  function automatic logic signed [WideW-1:0] join_sq(input sqp_t p);
    return (WideW'($signed(p.hh)) <<< (2 * GHalf))
         + (WideW'($signed(p.hl)) <<< (GHalf + 1))
         + WideW'(p.ll);
  endfunction

  // ---------------------------------------------------------------- control
  logic           adv;
  logic [Lat:1]   vld_q;

  // Hold everything while the output slot is full and stalled.
  assign in_stall_o  = out_valid_o & out_stall_i;
  assign adv         = ~in_stall_o;
  assign out_valid_o = vld_q[Lat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-1:1], in_valid_i};
    end
  end

  // ---------------------------------------------------------------- inputs
  logic signed [CoordW-1:0] p0 [3];
  logic signed [CoordW-1:0] p1 [3];
  logic signed [CoordW-1:0] q0 [3];
  logic signed [CoordW-1:0] q1 [3];

  assign p0[0] = first_start_x_i;
  assign p0[1] = first_start_y_i;
  assign p0[2] = first_start_z_i;
  assign p1[0] = first_end_x_i;
  assign p1[1] = first_end_y_i;
  assign p1[2] = first_end_z_i;
  assign q0[0] = second_start_x_i;
  assign q0[1] = second_start_y_i;
  assign q0[2] = second_start_z_i;
  assign q1[0] = second_end_x_i;
  assign q1[1] = second_end_y_i;
  assign q1[2] = second_end_z_i;

  // ---------------------------------------------------------------- data path
  // Direction and gap vectors travel alongside until the gap vector is built.
  logic signed [DiffW-1:0]   ud_q [1:StgQ][3];
  logic signed [DiffW-1:0]   vd_q [1:StgQ][3];
  logic signed [DiffW-1:0]   wd_q [1:StgPg][3];

  logic signed [2*DiffW-1:0] puu_q [3];
  logic signed [2*DiffW-1:0] puv_q [3];
  logic signed [2*DiffW-1:0] pvv_q [3];
  logic signed [2*DiffW-1:0] puw_q [3];
  logic signed [2*DiffW-1:0] pvw_q [3];

  // Gram terms A = U.U, B = U.V, C = V.V, E1 = U.W, E2 = V.W
  logic signed [DotW-1:0]    ga_q  [3:StgClamp-1];
  logic signed [DotW-1:0]    gb_q  [3:StgClamp-1];
  logic signed [DotW-1:0]    gc_q  [3:StgClamp-1];
  logic signed [DotW-1:0]    ge1_q [3:StgClamp-1];
  logic signed [DotW-1:0]    ge2_q [3:StgClamp-1];

  part_t                     pr_q [6];
  logic signed [WideW-1:0]   wp_q [6];
  logic signed [WideW-1:0]   det6_q, ns6_q, nt6_q;
  logic signed [WideW-1:0]   ns7_d, ds7_d, nt7_d, dt7_d;
  logic signed [WideW-1:0]   ns7_q, ds7_q, nt7_q, dt7_q;
  logic signed [WideW-1:0]   ns8_d, ds8_d, nt8_d, dt8_d;
  logic signed [WideW-1:0]   ns8_q, ds8_q, nt8_q, dt8_q;
  logic signed [DotW:0]      negp1, alt;

  logic        [QW-1:0]      qs_w, qt_w;
  logic signed [DiffW+QW:0]  pu_q [3];
  logic signed [DiffW+QW:0]  pv_q [3];
  logic signed [GW-1:0]      g_q  [3];
  sqp_t                      sp_q [3];
  logic signed [WideW-1:0]   sq_q [3];
  logic signed [WideW-1:0]   norm;

  logic [RadW-1:0]  sr_rad_q  [DistW+1];
  logic [RemW-1:0]  sr_rem_q  [DistW+1];
  logic [DistW-1:0] sr_root_q [DistW+1];
  logic [RemW-1:0]  sr_rin    [DistW+1];
  logic [RemW-1:0]  sr_trial  [DistW+1];
  logic [DistW:0]   sr_ge;

  // First clamp: solve for s, fall back to an end of the first segment.
  always_comb begin
    ns7_d = '0;
    ds7_d = det6_q;
    nt7_d = nt6_q;
    dt7_d = det6_q;
    if (det6_q <= 0) begin
      // parallel or degenerate: pin s to the start
      ds7_d = WideW'(1);
      nt7_d = WideW'(ge2_q[6]);
      dt7_d = WideW'(gc_q[6]);
    end else if (ns6_q < 0) begin
      nt7_d = WideW'(ge2_q[6]);
      dt7_d = WideW'(gc_q[6]);
    end else if (ns6_q > det6_q) begin
      ns7_d = det6_q;
      nt7_d = WideW'(ge2_q[6]) + WideW'(gb_q[6]);
      dt7_d = WideW'(gc_q[6]);
    end else begin
      ns7_d = ns6_q;
    end
  end

  // Second clamp: t out of range, redo s against that end of the second one.
  always_comb begin
    negp1 = -((DotW+1)'(ge1_q[7]));
    alt   = negp1 + (DotW+1)'(gb_q[7]);
    ns8_d = ns7_q;
    ds8_d = ds7_q;
    nt8_d = nt7_q;
    dt8_d = dt7_q;
    if (nt7_q < 0) begin
      nt8_d = '0;
      if (negp1 < 0) begin
        ns8_d = '0;
      end else if (negp1 > ga_q[7]) begin
        ns8_d = ds7_q;
      end else begin
        ns8_d = WideW'(negp1);
        ds8_d = WideW'(ga_q[7]);
      end
    end else if (nt7_q > dt7_q) begin
      nt8_d = dt7_q;
      if (alt < 0) begin
        ns8_d = '0;
      end else if (alt > ga_q[7]) begin
        ns8_d = ds7_q;
      end else begin
        ns8_d = WideW'(alt);
        ds8_d = WideW'(ga_q[7]);
      end
    end
  end

  ssd_qdiv u_div_s (
    .clk_i (clk_i),
    .adv_i (adv),
    .num_i (ns8_q),
    .den_i (ds8_q),
    .q_o   (qs_w)
  );

  ssd_qdiv u_div_t (
    .clk_i (clk_i),
    .adv_i (adv),
    .num_i (nt8_q),
    .den_i (dt8_q),
    .q_o   (qt_w)
  );

  assign norm = sq_q[0] + sq_q[1] + sq_q[2];

  // Square root: bring down two radicand bits, try the next root bit.
  always_comb begin
    sr_rin[0]   = '0;
    sr_trial[0] = '0;
    sr_ge[0]    = 1'b0;
    for (int j = 1; j <= DistW; j++) begin
      sr_rin[j]   = {sr_rem_q[j-1][RemW-3:0], sr_rad_q[j-1][RadW-1 -: 2]};
      sr_trial[j] = RemW'({sr_root_q[j-1], 2'b01});
      sr_ge[j]    = (sr_rin[j] >= sr_trial[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1: direction and gap vectors
      for (int i = 0; i < 3; i++) begin
        ud_q[1][i] <= DiffW'(p1[i]) - DiffW'(p0[i]);
        vd_q[1][i] <= DiffW'(q1[i]) - DiffW'(q0[i]);
        wd_q[1][i] <= DiffW'(p0[i]) - DiffW'(q0[i]);
      end
      for (int k = 2; k <= StgQ; k++) begin
        ud_q[k] <= ud_q[k-1];
        vd_q[k] <= vd_q[k-1];
      end
      for (int k = 2; k <= StgPg; k++) begin
        wd_q[k] <= wd_q[k-1];
      end

      // stage 2: component products
      for (int i = 0; i < 3; i++) begin
        puu_q[i] <= ud_q[1][i] * ud_q[1][i];
        puv_q[i] <= ud_q[1][i] * vd_q[1][i];
        pvv_q[i] <= vd_q[1][i] * vd_q[1][i];
        puw_q[i] <= ud_q[1][i] * wd_q[1][i];
        pvw_q[i] <= vd_q[1][i] * wd_q[1][i];
      end

      // stage 3: dot products
      ga_q[3]  <= DotW'(puu_q[0]) + DotW'(puu_q[1]) + DotW'(puu_q[2]);
      gb_q[3]  <= DotW'(puv_q[0]) + DotW'(puv_q[1]) + DotW'(puv_q[2]);
      gc_q[3]  <= DotW'(pvv_q[0]) + DotW'(pvv_q[1]) + DotW'(pvv_q[2]);
      ge1_q[3] <= DotW'(puw_q[0]) + DotW'(puw_q[1]) + DotW'(puw_q[2]);
      ge2_q[3] <= DotW'(pvw_q[0]) + DotW'(pvw_q[1]) + DotW'(pvw_q[2]);
      for (int k = 4; k < StgClamp; k++) begin
        ga_q[k]  <= ga_q[k-1];
        gb_q[k]  <= gb_q[k-1];
        gc_q[k]  <= gc_q[k-1];
        ge1_q[k] <= ge1_q[k-1];
        ge2_q[k] <= ge2_q[k-1];
      end

      // stage 4: partial products of AC, BB, B E2, C E1, A E2, B E1
      pr_q[0] <= split_mul(ga_q[3], gc_q[3]);
      pr_q[1] <= split_mul(gb_q[3], gb_q[3]);
      pr_q[2] <= split_mul(gb_q[3], ge2_q[3]);
      pr_q[3] <= split_mul(gc_q[3], ge1_q[3]);
      pr_q[4] <= split_mul(ga_q[3], ge2_q[3]);
      pr_q[5] <= split_mul(gb_q[3], ge1_q[3]);

      // stage 5: assemble wide products
      for (int i = 0; i < 6; i++) begin
        wp_q[i] <= join_mul(pr_q[i]);
      end

      // stage 6: determinant and raw numerators
      det6_q <= wp_q[0] - wp_q[1];
      ns6_q  <= wp_q[2] - wp_q[3];
      nt6_q  <= wp_q[4] - wp_q[5];

      // stages 7 and 8: clamping
      ns7_q <= ns7_d;
      ds7_q <= ds7_d;
      nt7_q <= nt7_d;
      dt7_q <= dt7_d;
      ns8_q <= ns8_d;
      ds8_q <= ds8_d;
      nt8_q <= nt8_d;
      dt8_q <= dt8_d;

      // stage 42: scale the directions by the quantized parameters
      for (int i = 0; i < 3; i++) begin
        pu_q[i] <= ud_q[StgQ][i] * $signed({1'b0, qs_w});
        pv_q[i] <= vd_q[StgQ][i] * $signed({1'b0, qt_w});
      end

      // stage 43: gap vector between the closest points
      for (int i = 0; i < 3; i++) begin
        g_q[i] <= (GW'(wd_q[StgPg][i]) <<< FracW) + GW'(pu_q[i]) - GW'(pv_q[i]);
      end

      // stages 44 and 45: squares of the components
      for (int i = 0; i < 3; i++) begin
        sp_q[i] <= split_sq(g_q[i]);
        sq_q[i] <= join_sq(sp_q[i]);
      end

      // stage 46: squared length, drop the extra fraction bits
      sr_rad_q[0]  <= norm[2*FracW +: RadW];
      sr_rem_q[0]  <= '0;
      sr_root_q[0] <= '0;

      // stages 47 to 80: one root bit each
      for (int j = 1; j <= DistW; j++) begin
        sr_rad_q[j]  <= sr_rad_q[j-1] << 2;
        sr_rem_q[j]  <= sr_ge[j] ? (sr_rin[j] - sr_trial[j]) : sr_rin[j];
        sr_root_q[j] <= {sr_root_q[j-1][DistW-2:0], sr_ge[j]};
      end
    end
  end

  assign distance_o = sr_root_q[DistW];

  // ---------------------------------------------------------------- checks
  a_det_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[6] |-> det6_q >= 0)
    else $error("determinant of the Gram matrix went negative");

  a_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[StgClamp] |-> (ns8_q >= 0 && ns8_q <= ds8_q && nt8_q >= 0 && nt8_q <= dt8_q))
    else $error("clamped parameter ratio outside the unit interval");

  a_quant_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[StgQ] |-> ((!qs_w[FracW] || qs_w[FracW-1:0] == '0) &&
                     (!qt_w[FracW] || qt_w[FracW-1:0] == '0)))
    else $error("quantized parameter above one");

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !distance_o[DistW-1])
    else $error("distance exceeds the coordinate span");

endmodule

// File: tb/sv/segment_segment_distance_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_segment_distance_tb: self-checking bench for the segment distance
// Drives directed and random pairs of 3D segments through the valid/stall
// input, predicts each distance with exact wide integer arithmetic and checks
// every result in order, with random idling and stall on both channels.
// ----------------------------------------------------------------------------

// Hold the expected distances and compare results against them.
class distance_scoreboard;
  typedef logic signed [199:0] wide_t;
  typedef logic signed [ssd_pkg::CoordW-1:0] coord_t;

  logic [ssd_pkg::DistW-1:0] pending_distances[$];
  int mismatches = 0;

  // Quantize num/den to unsigned Q1.32, clamped to [0,1].
  static function automatic wide_t quantize(wide_t num, wide_t den);
    if (den <= 0 || num <= 0) return 0;
    if (num >= den) return wide_t'(1) <<< ssd_pkg::FracW;
    return (num <<< ssd_pkg::FracW) / den;
  endfunction

  // Exact closest distance between segments P0-P1 and Q0-Q1, Q18.16.
  static function automatic logic [ssd_pkg::DistW-1:0] closest_distance(coord_t c[12]);
    wide_t u[3], v[3], w[3], g[3];
    wide_t aa, bb, cc, e1, e2, det, ns, ds, nt, dt, negp1, alt, n2, top, qs, qt, cand;
    logic [ssd_pkg::DistW-1:0] root;
    for (int i = 0; i < 3; i++) begin
      u[i] = wide_t'(c[3 + i]) - wide_t'(c[i]);
      v[i] = wide_t'(c[9 + i]) - wide_t'(c[6 + i]);
      w[i] = wide_t'(c[i]) - wide_t'(c[6 + i]);
    end
    aa = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
    bb = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    cc = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    e1 = u[0] * w[0] + u[1] * w[1] + u[2] * w[2];
    e2 = v[0] * w[0] + v[1] * w[1] + v[2] * w[2];
    det = aa * cc - bb * bb;
    ds = det;
    dt = det;
    if (det <= 0) begin
      // parallel or degenerate: pin s to the first start point
      ns = 0; ds = 1; nt = e2; dt = cc;
    end else begin
      ns = bb * e2 - cc * e1;
      nt = aa * e2 - bb * e1;
      if (ns < 0) begin
        ns = 0; nt = e2; dt = cc;
      end else if (ns > ds) begin
        ns = ds; nt = e2 + bb; dt = cc;
      end
    end
    negp1 = -e1;
    if (nt < 0) begin
      nt = 0;
      if (negp1 < 0) ns = 0;
      else if (negp1 > aa) ns = ds;
      else begin
        ns = negp1; ds = aa;
      end
    end else if (nt > dt) begin
      nt = dt;
      alt = negp1 + bb;
      if (alt < 0) ns = 0;
      else if (alt > aa) ns = ds;
      else begin
        ns = alt; ds = aa;
      end
    end
    qs = quantize(ns, ds);
    qt = quantize(nt, dt);
    n2 = 0;
    for (int i = 0; i < 3; i++) begin
      g[i] = (w[i] <<< ssd_pkg::FracW) + u[i] * qs - v[i] * qt;
      n2 += g[i] * g[i];
    end
    top = n2 >>> 64;
    root = '0;
    for (int b = ssd_pkg::DistW - 1; b >= 0; b--) begin
      cand = wide_t'({1'b0, root | (34'd1 << b)});
      if (cand * cand <= top) root[b] = 1'b1;
    end
    return root;
  endfunction

  function void note_request(coord_t c[12]);
    pending_distances.push_back(closest_distance(c));
  endfunction

  function void check_distance(logic [ssd_pkg::DistW-1:0] got);
    logic [ssd_pkg::DistW-1:0] want;
    if (pending_distances.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected distance %0d, nothing pending", got);
      return;
    end
    want = pending_distances.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("distance mismatch: expected %0d actual %0d", want, got);
    end
  endfunction
endclass

module segment_segment_distance_tb;
  import ssd_pkg::*;

  typedef logic signed [CoordW-1:0] coord_t;

  localparam int HoldCycles    = 300;   // long receiver hold-off
  localparam int WatchdogLimit = 5000;  // cycles with no handshake at all
  localparam int RandomCount   = 1330;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [DistW-1:0] distance_o;
  coord_t coord[12];

  // Stretch with no idling on either side, and the hold-off trigger.
  bit calm = 1'b0;
  bit hold_toggle = 1'b0;

  distance_scoreboard board = new();

  always #1 clk_i = ~clk_i;

  segment_segment_distance dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .first_start_x_i(coord[0]),  .first_start_y_i(coord[1]),  .first_start_z_i(coord[2]),
    .first_end_x_i(coord[3]),    .first_end_y_i(coord[4]),    .first_end_z_i(coord[5]),
    .second_start_x_i(coord[6]), .second_start_y_i(coord[7]), .second_start_z_i(coord[8]),
    .second_end_x_i(coord[9]),   .second_end_y_i(coord[10]),  .second_end_z_i(coord[11]),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .distance_o(distance_o)
  );

  initial foreach (coord[i]) coord[i] = '0;

  // Receiver: random stall, long hold-off on request, none while calm.
  int hold_left = 0;
  bit hold_seen = 1'b0;
  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 29);
    end
  end

  // Check each accepted result; sampled values are the pre-edge ones.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_distance(distance_o);
  end

  // Watchdog: count cycles in which neither channel moves.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one request, hold it until taken, then idle each next cycle at random.
  task automatic send_request(coord_t c[12]);
    for (int i = 0; i < 12; i++) coord[i] <= c[i];
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(c);
    if (!calm && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (!calm && $urandom_range(99) < 29);
    end
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (board.pending_distances.size() != 0) @(posedge clk_i);
  endtask

  // Random coordinate: full 32-bit range, within 20 units, or within 200 LSBs.
  function automatic coord_t random_coord(int flavor);
    case (flavor)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(65536 * 40)) - 65536 * 20);
      default: return coord_t'($signed($urandom_range(400)) - 200);
    endcase
  endfunction

  task automatic send_segments(coord_t p0[3], coord_t p1[3], coord_t q0[3], coord_t q1[3]);
    coord_t c[12];
    for (int i = 0; i < 3; i++) begin
      c[i] = p0[i]; c[3 + i] = p1[i]; c[6 + i] = q0[i]; c[9 + i] = q1[i];
    end
    send_request(c);
  endtask

  task automatic run_directed();
    coord_t c[12];
    coord_t mx = 32'sh7FFF_FFFF, mn = 32'sh8000_0000, one = 32'sh0001_0000;
    foreach (c[i]) c[i] = mx;
    send_request(c);                       // all coincident at the maximum
    foreach (c[i]) c[i] = mn;
    send_request(c);
    foreach (c[i]) c[i] = (i < 6) ? mx : mn;  // farthest apart points
    send_request(c);
    foreach (c[i]) c[i] = (i % 2) ? mx : mn;
    send_request(c);
    foreach (c[i]) c[i] = ((i / 3) % 2) ? mn : mx;
    send_request(c);
    // crossing segments, distance one unit
    send_segments('{-one, 0, 0}, '{one, 0, 0}, '{0, -one, one}, '{0, one, one});
    // parallel, overlapping
    send_segments('{0, 0, 0}, '{4 * one, 0, 0}, '{one, one, 0}, '{5 * one, one, 0});
    // parallel, reversed and apart
    send_segments('{0, 0, 0}, '{one, 0, 0}, '{9 * one, one, 0}, '{3 * one, one, 0});
    // coincident segments
    send_segments('{one, 2 * one, 3 * one}, '{-one, 0, one},
                  '{one, 2 * one, 3 * one}, '{-one, 0, one});
    // degenerate first, degenerate second, both degenerate
    send_segments('{one, one, one}, '{one, one, one}, '{0, 0, 0}, '{4 * one, 0, 0});
    send_segments('{0, 0, 0}, '{4 * one, 0, 0}, '{one, one, one}, '{one, one, one});
    send_segments('{one, 0, 0}, '{one, 0, 0}, '{0, one, 0}, '{0, one, 0});
    // clamps: s below zero, s above one, t below zero, t above one
    send_segments('{2 * one, 0, 0}, '{5 * one, 0, 0}, '{0, -one, one}, '{0, one, one});
    send_segments('{-5 * one, 0, 0}, '{-2 * one, 0, 0}, '{0, -one, one}, '{0, one, one});
    send_segments('{-one, 0, 0}, '{one, 0, 0}, '{0, 2 * one, one}, '{0, 5 * one, one});
    send_segments('{-one, 0, 0}, '{one, 0, 0}, '{0, -5 * one, one}, '{0, -2 * one, one});
    // corner to corner, both clamped
    send_segments('{2 * one, 0, 0}, '{5 * one, 0, 0}, '{0, 2 * one, one}, '{0, 5 * one, one});
    // tiny fractional values
    send_segments('{1, 0, -1}, '{0, 1, 0}, '{-1, -1, 1}, '{1, 1, 1});
  endtask

  task automatic run_random();
    coord_t c[12];
    coord_t p0[3], p1[3], q0[3], q1[3];
    int flavor, shape, k;
    for (int n = 0; n < RandomCount; n++) begin
      if (n == 200) hold_toggle = ~hold_toggle;  // receiver holds, sender keeps going
      calm = (n >= 500 && n < 650);
      if (n == 900) drain_requests();
      flavor = $urandom_range(2);
      shape = $urandom_range(9);
      for (int i = 0; i < 3; i++) begin
        p0[i] = random_coord(flavor); p1[i] = random_coord(flavor);
        q0[i] = random_coord(flavor); q1[i] = random_coord(flavor);
      end
      k = $urandom_range(1, 3);
      for (int i = 0; i < 3; i++) begin
        case (shape)
          0: p1[i] = p0[i];                                  // degenerate first
          1: q1[i] = q0[i];                                  // degenerate second
          2: q1[i] = q0[i] + k * (p1[i] - p0[i]) / 4;        // parallel
          3: q1[i] = q0[i] - (p1[i] - p0[i]);                // antiparallel
          4: begin
            q0[i] = p0[i]; q1[i] = p1[i];                    // coincident
          end
          default: ;
        endcase
      end
      for (int i = 0; i < 3; i++) begin
        c[i] = p0[i]; c[3 + i] = p1[i]; c[6 + i] = q0[i]; c[9 + i] = q1[i];
      end
      send_request(c);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    drain_requests();  // sender pauses until every distance has arrived
    run_random();
    drain_requests();
    repeat (100) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_distances.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
